// ----- sv/tmeu_pkg.sv -----
// ----------------------------------------------------------------------------
// tmeu_pkg
// Shared types and constants of the tape machine execute unit: tape geometry,
// command and register codes, transfer structs and the control state type.
// ----------------------------------------------------------------------------
package tmeu_pkg;

	localparam int unsigned TAPE_DEPTH = 65536;
	localparam int unsigned TAPE_AW    = $clog2(TAPE_DEPTH);
	localparam int unsigned LIM_W      = TAPE_AW + 1;
	localparam int unsigned ISIZE_W    = 17;
	localparam int unsigned APB_AW     = 4;
	localparam int unsigned APB_DW     = 32;

	localparam logic [ISIZE_W-1:0] ISIZE_RST = ISIZE_W'(30000);
	localparam logic [7:0]         CELL_MAX  = 8'd255;

	localparam logic [3:0] CMD_CLEAR = 4'd0;
	localparam logic [3:0] CMD_ADD   = 4'd1;
	localparam logic [3:0] CMD_SUB   = 4'd2;
	localparam logic [3:0] CMD_LEFT  = 4'd3;
	localparam logic [3:0] CMD_RIGHT = 4'd4;
	localparam logic [3:0] CMD_OPEN  = 4'd5;
	localparam logic [3:0] CMD_CLOSE = 4'd6;
	localparam logic [3:0] CMD_READ  = 4'd7;
	localparam logic [3:0] CMD_WRITE = 4'd8;
	localparam logic [3:0] CMD_SCANL = 4'd9;
	localparam logic [3:0] CMD_SCANR = 4'd10;

	localparam logic [1:0] REG_INIT_SIZE = 2'd0;
	localparam logic [1:0] REG_GROW      = 2'd1;
	localparam logic [1:0] REG_EOF_MODE  = 2'd2;

	localparam logic [1:0] EOF_ONES = 2'd1;
	localparam logic [1:0] EOF_CLR  = 2'd2;

	typedef struct packed {
		logic [3:0]  cmd;
		logic [15:0] repeat_count;
		logic [7:0]  in_byte;
		logic        in_eof;
	} item_t;

	typedef struct packed {
		logic        emit_valid;
		logic [7:0]  out_byte;
		logic        jump_taken;
		logic [15:0] head_position;
	} result_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_SCAN_L,
		ST_SCAN_R
	} state_t;

endpackage

// ----- sv/tape_machine_execute_unit_core.sv -----
// ----------------------------------------------------------------------------
// tape_machine_execute_unit_core
// Executes one run-length-compressed tape instruction per transfer on a byte
// tape held in a synchronous single-port-read memory, with an APB register port.
// ----------------------------------------------------------------------------
// After reset the block sweeps the tape to zero, one cell per cycle, with busy
// high; register writes are taken during the sweep. An instruction is taken
// when start is high and busy is low. Most instructions read the cell under
// the head from the tape memory, then modify, write back and register the
// result. Zero scans read one further cell per cycle until the scan ends.
// The result is registered on result, with done high for exactly one cycle,
// the cycle after the last execute cycle; the receiver cannot stall it and
// the next instruction can be taken in that same cycle.
module tape_machine_execute_unit_core
	import tmeu_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  item_t             item,
	output logic              done,
	output result_t           result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	state_t               state_q, state_d;
	logic [TAPE_AW-1:0]   clr_addr_q;
	logic [TAPE_AW-1:0]   head_q;
	logic [TAPE_AW-1:0]   scan_addr_q;
	item_t                item_q;
	result_t              result_q, result_d;
	logic                 done_q;
	logic [ISIZE_W-1:0]   isize_q;
	logic                 grow_q;
	logic [1:0]           eof_mode_q;

	logic [7:0]           tape_mem [TAPE_DEPTH];
	logic [7:0]           rd_data_q;
	logic [TAPE_AW-1:0]   rd_addr;
	logic                 wr_en;
	logic [TAPE_AW-1:0]   wr_addr;
	logic [7:0]           wr_data;

	logic [LIM_W-1:0]     lim;
	logic [LIM_W-1:0]     right_sum;
	logic [LIM_W-1:0]     head_inc;
	logic [LIM_W-1:0]     scan_inc;
	logic                 rd_zero;
	logic                 scan_l_go, scan_r_go, scan_l_end, scan_r_end;
	logic                 fin;
	logic [TAPE_AW-1:0]   head_d;
	logic                 cfg_we;

	// usable limit
	always_comb begin
		if (grow_q) begin
			lim = LIM_W'(TAPE_DEPTH);
		end else if (isize_q == '0) begin
			lim = LIM_W'(1);
		end else if (isize_q > ISIZE_W'(TAPE_DEPTH)) begin
			lim = LIM_W'(TAPE_DEPTH);
		end else begin
			lim = LIM_W'(isize_q);
		end
	end

	assign rd_zero   = (rd_data_q == 8'd0);
	assign right_sum = {1'b0, head_q} + LIM_W'(item_q.repeat_count);
	assign head_inc  = {1'b0, head_q} + LIM_W'(1);
	assign scan_inc  = {1'b0, scan_addr_q} + LIM_W'(1);

	assign scan_l_go  = (state_q == ST_EXEC) && (item_q.cmd == CMD_SCANL) && !rd_zero &&
		(head_q != '0);
	assign scan_r_go  = (state_q == ST_EXEC) && (item_q.cmd == CMD_SCANR) && !rd_zero &&
		(head_inc < lim);
	assign scan_l_end = rd_zero || (scan_addr_q == '0);
	assign scan_r_end = rd_zero || (scan_inc >= lim);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == TAPE_AW'(TAPE_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (scan_l_go) begin
					state_d = ST_SCAN_L;
				end else if (scan_r_go) begin
					state_d = ST_SCAN_R;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN_L: begin
				if (scan_l_end) begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN_R: begin
				if (scan_r_end) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs and datapath control
	always_comb begin
		rd_addr  = head_q;
		wr_en    = 1'b0;
		wr_addr  = head_q;
		wr_data  = rd_data_q;
		fin      = 1'b0;
		head_d   = head_q;
		result_d = '0;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_addr_q;
				wr_data = 8'd0;
			end
			ST_EXEC: begin
				fin = !scan_l_go && !scan_r_go;
				case (item_q.cmd)
					CMD_CLEAR: begin
						wr_en   = 1'b1;
						wr_data = 8'd0;
					end
					CMD_ADD: begin
						wr_en   = 1'b1;
						wr_data = rd_data_q + item_q.repeat_count[7:0];
					end
					CMD_SUB: begin
						wr_en   = 1'b1;
						wr_data = rd_data_q - item_q.repeat_count[7:0];
					end
					CMD_LEFT: begin
						if (item_q.repeat_count <= head_q) begin
							head_d = head_q - item_q.repeat_count;
						end
					end
					CMD_RIGHT: begin
						if (right_sum < lim) begin
							head_d = right_sum[TAPE_AW-1:0];
						end
					end
					CMD_OPEN: begin
						result_d.jump_taken = rd_zero;
					end
					CMD_CLOSE: begin
						result_d.jump_taken = !rd_zero;
					end
					CMD_READ: begin
						wr_en = 1'b1;
						if (!item_q.in_eof) begin
							wr_data = item_q.in_byte;
						end else if (eof_mode_q == EOF_ONES) begin
							wr_data = CELL_MAX;
						end else if (eof_mode_q == EOF_CLR) begin
							wr_data = 8'd0;
						end
					end
					CMD_WRITE: begin
						result_d.emit_valid = 1'b1;
						result_d.out_byte   = (rd_data_q == CELL_MAX) ? 8'd0 : rd_data_q;
					end
					CMD_SCANL: begin
						rd_addr = head_q - TAPE_AW'(1);
					end
					CMD_SCANR: begin
						rd_addr = head_inc[TAPE_AW-1:0];
					end
					default: begin
					end
				endcase
			end
			ST_SCAN_L: begin
				rd_addr = scan_addr_q - TAPE_AW'(1);
				fin     = scan_l_end;
				if (rd_zero) begin
					head_d = scan_addr_q;
				end
			end
			ST_SCAN_R: begin
				rd_addr = scan_inc[TAPE_AW-1:0];
				fin     = scan_r_end;
				if (rd_zero) begin
					head_d = scan_addr_q;
				end
			end
			default: begin
			end
		endcase
		result_d.head_position = 16'(head_d);
	end

	// tape memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			tape_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= tape_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		scan_addr_q <= rd_addr;
		if (start && !busy) begin
			item_q <= item;
		end
		if (fin) begin
			result_q <= result_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			head_q     <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + TAPE_AW'(1);
			end
			if (fin) begin
				head_q <= head_d;
			end
		end
	end

	// register port
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			isize_q    <= ISIZE_RST;
			grow_q     <= 1'b1;
			eof_mode_q <= 2'd0;
		end else if (cfg_we) begin
			case (paddr[3:2])
				REG_INIT_SIZE: isize_q    <= pwdata[ISIZE_W-1:0];
				REG_GROW:      grow_q     <= pwdata[0];
				REG_EOF_MODE:  eof_mode_q <= pwdata[1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_INIT_SIZE: prdata = APB_DW'(isize_q);
			REG_GROW:      prdata = APB_DW'(grow_q);
			REG_EOF_MODE:  prdata = APB_DW'(eof_mode_q);
			default:       prdata = '0;
		endcase
	end

	assign pready = 1'b1;
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

// ----- verif/tape_machine_execute_unit_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tape_machine_execute_unit_core_tb
// Drives tape instructions through the start/busy port and APB register
// writes, keeps a shadow tape and head to predict every result, and checks
// each done strobe field by field. A short directed run covers the field
// extremes and edge cases, then randomized phases run under several register
// settings and sender gap rates.
// ----------------------------------------------------------------------------
module tape_machine_execute_unit_core_tb
	import tmeu_pkg::*;
();

	localparam logic [3:0] CMD_NOP        = 4'd11;
	localparam logic [3:0] CMD_UNUSED_MAX = 4'd15;
	localparam logic [1:0] EOF_KEEP       = 2'd0;
	localparam logic [1:0] EOF_UNUSED     = 2'd3;
	localparam int unsigned MAX_REPORTS   = 10;
	localparam int unsigned CYCLE_LIMIT   = 1000000;

	class tape_shadow;
		bit [7:0]    cells [TAPE_DEPTH];
		int unsigned head;
		int unsigned init_size;
		bit          grow;
		bit [1:0]    eof_mode;
		result_t     due_results [$];
		int unsigned faults;

		function new();
			head      = 0;
			init_size = 32'(ISIZE_RST);
			grow      = 1'b1;
			eof_mode  = EOF_KEEP;
			faults    = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [APB_DW-1:0] val);
			case (idx)
				REG_INIT_SIZE: init_size = 32'(val[ISIZE_W-1:0]);
				REG_GROW:      grow      = val[0];
				REG_EOF_MODE:  eof_mode  = val[1:0];
				default: ;
			endcase
		endfunction

		function int unsigned usable_cells();
			if (grow)
				return TAPE_DEPTH;
			if (init_size > TAPE_DEPTH)
				return TAPE_DEPTH;
			if (init_size == 0)
				return 1;
			return init_size;
		endfunction

		function void take_instr(item_t it);
			int unsigned lim;
			int unsigned h;
			int unsigned p;
			int unsigned rep;
			result_t     r;
			lim = usable_cells();
			h   = head % TAPE_DEPTH;
			rep = 32'(it.repeat_count);
			r   = '0;
			case (it.cmd)
				CMD_CLEAR: cells[h] = 8'd0;
				CMD_ADD:   cells[h] = cells[h] + it.repeat_count[7:0];
				CMD_SUB:   cells[h] = cells[h] - it.repeat_count[7:0];
				CMD_LEFT: begin
					if (rep <= h)
						h = h - rep;
				end
				CMD_RIGHT: begin
					if (h + rep < lim)
						h = h + rep;
				end
				CMD_OPEN:  r.jump_taken = (cells[h] == 8'd0);
				CMD_CLOSE: r.jump_taken = (cells[h] != 8'd0);
				CMD_READ: begin
					if (!it.in_eof)
						cells[h] = it.in_byte;
					else if (eof_mode == EOF_ONES)
						cells[h] = CELL_MAX;
					else if (eof_mode == EOF_CLR)
						cells[h] = 8'd0;
				end
				CMD_WRITE: begin
					r.emit_valid = 1'b1;
					r.out_byte   = cells[h] % CELL_MAX;
				end
				CMD_SCANL: begin
					p = h;
					while (cells[p] != 8'd0 && p != 0)
						p--;
					if (cells[p] == 8'd0)
						h = p;
				end
				CMD_SCANR: begin
					if (cells[h] != 8'd0) begin
						p = h + 1;
						while (p < lim && cells[p] != 8'd0)
							p++;
						if (p < lim)
							h = p;
					end
				end
				default: ;
			endcase
			head            = h;
			r.head_position = 16'(h);
			due_results.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (due_results.size() == 0) begin
				faults++;
				if (faults <= MAX_REPORTS)
					$display("%0t unexpected result emit=%0d byte=%0d jump=%0d head=%0d",
						$time, got.emit_valid, got.out_byte, got.jump_taken,
						got.head_position);
				return;
			end
			want = due_results.pop_front();
			if (got.emit_valid !== want.emit_valid || got.out_byte !== want.out_byte ||
					got.jump_taken !== want.jump_taken ||
					got.head_position !== want.head_position) begin
				faults++;
				if (faults <= MAX_REPORTS)
					$display("%0t mismatch e/b/j/h want %0d %0d %0d %0d got %0d %0d %0d %0d",
						$time, want.emit_valid, want.out_byte, want.jump_taken,
						want.head_position, got.emit_valid, got.out_byte,
						got.jump_taken, got.head_position);
			end
		endfunction

		function int unsigned outstanding();
			return due_results.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	item_t             instr;
	logic              done;
	result_t           res;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	tape_shadow  shadow = new();
	int unsigned gap_pct;
	int unsigned cycle_count;

	tape_machine_execute_unit_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (instr),
		.done    (done),
		.result  (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			shadow.check_result(res);
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tape_machine_execute_unit_core_tb NOT OK");
		$finish;
	end

	function automatic item_t instr_of(logic [3:0] cmd, logic [15:0] rep, logic [7:0] byte_in,
			logic eof);
		return item_t'{cmd, rep, byte_in, eof};
	endfunction

	function automatic item_t rand_item();
		item_t       it;
		int unsigned pick;
		it.repeat_count = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(4));
		it.in_byte      = 8'($urandom);
		it.in_eof       = ($urandom_range(3) == 0);
		pick            = $urandom_range(99);
		if (pick < 18)
			it.cmd = CMD_ADD;
		else if (pick < 26)
			it.cmd = CMD_SUB;
		else if (pick < 41)
			it.cmd = CMD_RIGHT;
		else if (pick < 52)
			it.cmd = CMD_LEFT;
		else if (pick < 55) begin
			// jump back to the start of the tape
			it.cmd          = CMD_LEFT;
			it.repeat_count = 16'(shadow.head);
		end else if (pick < 59)
			it.cmd = CMD_CLEAR;
		else if (pick < 64)
			it.cmd = CMD_OPEN;
		else if (pick < 69)
			it.cmd = CMD_CLOSE;
		else if (pick < 77)
			it.cmd = CMD_READ;
		else if (pick < 85)
			it.cmd = CMD_WRITE;
		else if (pick < 90)
			it.cmd = CMD_SCANL;
		else if (pick < 95)
			it.cmd = CMD_SCANR;
		else if (pick < 98)
			it.cmd = CMD_NOP;
		else
			it.cmd = 4'($urandom_range(CMD_UNUSED_MAX, CMD_NOP + 1));
		return it;
	endfunction

	task automatic send_item(input item_t it);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		instr <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		shadow.take_instr(it);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [APB_DW-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		shadow.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (shadow.outstanding() != 0)
			@(posedge clk);
		repeat (6)
			@(posedge clk);
	endtask

	task automatic run_phase(input logic [APB_DW-1:0] isize, input logic grow,
			input logic [1:0] eof, input int unsigned gap, input int unsigned n);
		drain();
		reg_write(REG_INIT_SIZE, isize);
		reg_write(REG_GROW, APB_DW'(grow));
		reg_write(REG_EOF_MODE, APB_DW'(eof));
		gap_pct = gap;
		repeat (n)
			send_item(rand_item());
	endtask

	initial begin
		arst_n  <= 1'b0;
		start   <= 1'b0;
		instr   <= '0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		gap_pct = 0;
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers are taken during the clearing sweep
		reg_write(REG_INIT_SIZE, APB_DW'(ISIZE_RST));
		reg_write(REG_GROW, APB_DW'(1));
		reg_write(REG_EOF_MODE, APB_DW'(EOF_ONES));

		send_item(instr_of(CMD_OPEN, 16'd0, 8'h00, 1'b0));
		send_item(instr_of(CMD_CLOSE, 16'd0, 8'h00, 1'b0));
		send_item(instr_of(CMD_ADD, 16'hFFFF, 8'h00, 1'b0));
		send_item(instr_of(CMD_CLOSE, 16'd0, 8'h00, 1'b0));
		send_item(instr_of(CMD_WRITE, 16'd0, 8'h00, 1'b0));
		send_item(instr_of(CMD_SUB, 16'd1, 8'h00, 1'b0));
		send_item(instr_of(CMD_WRITE, 16'd0, 8'h00, 1'b0));
		send_item(instr_of(CMD_READ, 16'd0, 8'h5A, 1'b1));
		send_item(instr_of(CMD_READ, 16'd0, 8'h00, 1'b0));
		send_item(instr_of(CMD_READ, 16'd0, 8'hFF, 1'b0));
		send_item(instr_of(CMD_CLEAR, 16'd0, 8'h00, 1'b0));
		send_item(instr_of(CMD_LEFT, 16'd1, 8'h00, 1'b0));
		send_item(instr_of(CMD_RIGHT, 16'hFFFF, 8'h00, 1'b0));
		send_item(instr_of(CMD_RIGHT, 16'd1, 8'h00, 1'b0));
		send_item(instr_of(CMD_ADD, 16'd1, 8'h00, 1'b0));
		send_item(instr_of(CMD_SCANR, 16'd0, 8'h00, 1'b0));
		send_item(instr_of(CMD_SCANL, 16'd0, 8'h00, 1'b0));
		send_item(instr_of(CMD_LEFT, 16'hFFFF, 8'h00, 1'b0));
		send_item(instr_of(CMD_LEFT, 16'd65534, 8'h00, 1'b0));
		send_item(instr_of(CMD_ADD, 16'd3, 8'h00, 1'b0));
		send_item(instr_of(CMD_RIGHT, 16'd1, 8'h00, 1'b0));
		send_item(instr_of(CMD_ADD, 16'd5, 8'h00, 1'b0));
		send_item(instr_of(CMD_SCANL, 16'd0, 8'h00, 1'b0));
		send_item(instr_of(CMD_SCANR, 16'd0, 8'h00, 1'b0));
		send_item(instr_of(CMD_NOP, 16'hFFFF, 8'hFF, 1'b1));
		send_item(instr_of(CMD_UNUSED_MAX, 16'd7, 8'h00, 1'b0));

		run_phase(APB_DW'(ISIZE_RST), 1'b1, EOF_CLR, 0, 90);
		// leave the head past the small tape set up next
		send_item(instr_of(CMD_RIGHT, 16'd20, 8'h00, 1'b0));
		run_phase(APB_DW'(8), 1'b0, EOF_ONES, 66, 70);
		run_phase(APB_DW'(1), 1'b0, EOF_KEEP, 11, 60);
		run_phase(APB_DW'(0), 1'b0, EOF_UNUSED, 0, 40);
		run_phase(APB_DW'(TAPE_DEPTH), 1'b0, EOF_ONES, 66, 70);
		run_phase(APB_DW'({ISIZE_W{1'b1}}), 1'b0, EOF_CLR, 11, 50);
		run_phase(APB_DW'(200), 1'b1, EOF_KEEP, 0, 70);

		drain();
		if (shadow.faults == 0)
			$display("tape_machine_execute_unit_core_tb OK");
		else
			$display("tape_machine_execute_unit_core_tb NOT OK");
		$finish;
	end

endmodule
